FILE: rtl/lifeg_pkg.sv
// Shared types, constants and row-level functions for the life grid engine.
// No dependencies; used by every module in rtl/.
`default_nettype none
package lifeg_pkg;

  localparam int GRID_SIDE = 128;
  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int COORD_W   = 7;
  localparam int CHUNK_W   = (GRID_SIDE < 16) ? GRID_SIDE : 16;
  localparam int NCHUNK    = (GRID_SIDE + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = NCHUNK * CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);
  localparam int NCHUNK_W  = $clog2(NCHUNK + 1);
  localparam int COUNT_W   = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [GRID_SIDE-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_ROW = IDX_W'(GRID_SIDE - 1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_P0,
    S_P1,
    S_P2,
    S_CALC,
    S_SHIFT,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
  } cnt_ctrl_t;

  // next generation of row m given the rows above (a) and below (b)
  function automatic row_t evolve(row_t a, row_t m, row_t b, logic wrap);
    row_t al, ar, ml, mr, bl, br, res;
    logic [3:0] s;
    al = {a[GRID_SIDE-2:0], wrap & a[GRID_SIDE-1]};
    ar = {wrap & a[0], a[GRID_SIDE-1:1]};
    ml = {m[GRID_SIDE-2:0], wrap & m[GRID_SIDE-1]};
    mr = {wrap & m[0], m[GRID_SIDE-1:1]};
    bl = {b[GRID_SIDE-2:0], wrap & b[GRID_SIDE-1]};
    br = {wrap & b[0], b[GRID_SIDE-1:1]};
    for (int c = 0; c < GRID_SIDE; c++) begin
      s = 4'(al[c]) + 4'(a[c]) + 4'(ar[c]) + 4'(ml[c]) + 4'(mr[c])
        + 4'(bl[c]) + 4'(b[c]) + 4'(br[c]);
      res[c] = (s == 4'd3) | ((s == 4'd2) & m[c]);
    end
    return res;
  endfunction

  function automatic logic [CHUNK_CNT_W-1:0] popcnt(logic [CHUNK_W-1:0] v);
    logic [CHUNK_CNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      sum = sum + CHUNK_CNT_W'(v[i]);
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lifeg_ram.sv
// Grid storage: one row of cells per entry, one write and one read port.
// Depends on lifeg_pkg for row and index types.
`default_nettype none
module lifeg_ram (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire lifeg_pkg::idx_t waddr,
  input  wire lifeg_pkg::row_t wdata,
  input  wire logic            re,
  input  wire lifeg_pkg::idx_t raddr,
  output lifeg_pkg::row_t      rdata
);

  lifeg_pkg::row_t mem [lifeg_pkg::GRID_SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lifeg_cnt.sv
// Change counter: takes one row of flip flags, adds one chunk per cycle,
// saturating total. Depends on lifeg_pkg.
`default_nettype none
module lifeg_cnt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lifeg_pkg::cnt_ctrl_t ctrl,
  input  wire lifeg_pkg::row_t      diff,
  output logic                      busy,
  output logic [lifeg_pkg::COUNT_W-1:0] total
);

  logic [lifeg_pkg::PAD_W-1:0]    shreg;
  logic [lifeg_pkg::NCHUNK_W-1:0] left;
  logic [lifeg_pkg::COUNT_W:0]    sum;
  logic [lifeg_pkg::COUNT_W-1:0]  total_next;

  assign busy = (left != '0);

  always_comb begin
    sum = {1'b0, total}
        + (lifeg_pkg::COUNT_W + 1)'(lifeg_pkg::popcnt(shreg[lifeg_pkg::CHUNK_W-1:0]));
    total_next = sum[lifeg_pkg::COUNT_W] ? lifeg_pkg::COUNT_MAX
                                         : sum[lifeg_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= '0;
      total <= '0;
    end else if (ctrl.clear) begin
      total <= '0;
    end else if (ctrl.load) begin
      shreg <= lifeg_pkg::PAD_W'(diff);
      left  <= lifeg_pkg::NCHUNK_W'(lifeg_pkg::NCHUNK);
    end else if (busy) begin
      shreg <= shreg >> lifeg_pkg::CHUNK_W;
      left  <= left - 1'b1;
      total <= total_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/life_automaton_grid_engine_top.sv
// Life grid engine top: command sequencer, three-row window, B3/S23 row update.
// Depends on lifeg_pkg, lifeg_ram and lifeg_cnt. One command at a time, busy until done.
// A step reads the grid row by row and writes each new row back; the change counter (16 cells
//   per cycle) counts its flips, and the next row waits while the counter is busy.
// A new command is taken only when idle. done is a one-cycle strobe; results cannot be stalled.
// After rst (synchronous) a clearing pass writes every row dead before the engine goes idle.
`default_nettype none
module life_automaton_grid_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [6:0]  column,
  input  wire logic [6:0]  row,
  input  wire logic        cell_in,
  output logic             done,
  output logic             cell_out,
  output logic [14:0]      changed_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  lifeg_pkg::state_t state, state_next;
  lifeg_pkg::idx_t   r, r_next;
  logic [lifeg_pkg::IDX_W:0] r2;

  logic edge_mode;

  lifeg_pkg::cmd_t cmd_q;
  lifeg_pkg::idx_t col_q, row_q;
  logic            cellin_q, inside_q;

  lifeg_pkg::row_t above, mid, below, first;
  lifeg_pkg::row_t a_eff, b_eff, new_row, merged;

  logic            ram_we, ram_re;
  lifeg_pkg::idx_t ram_waddr, ram_raddr;
  lifeg_pkg::row_t ram_wdata, ram_rdata;

  lifeg_pkg::cnt_ctrl_t cnt_ctrl;
  logic                 cnt_busy;
  logic [lifeg_pkg::COUNT_W-1:0] cnt_total;

  logic done_next, cell_next;
  logic [lifeg_pkg::COUNT_W-1:0] count_next;
  logic inside_in;

  lifeg_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lifeg_cnt u_cnt (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cnt_ctrl),
    .diff  (new_row ^ mid),
    .busy  (cnt_busy),
    .total (cnt_total)
  );

  assign busy = (state != lifeg_pkg::S_IDLE);
  assign r2   = {1'b0, r} + (lifeg_pkg::IDX_W + 1)'(2);
  assign inside_in = (32'(column) < lifeg_pkg::GRID_SIDE) &&
                     (32'(row) < lifeg_pkg::GRID_SIDE);

  always_comb begin
    a_eff   = (!edge_mode && r == '0) ? '0 : above;
    b_eff   = (!edge_mode && r == lifeg_pkg::LAST_ROW) ? '0 : below;
    new_row = lifeg_pkg::evolve(a_eff, mid, b_eff, edge_mode);
    merged  = ram_rdata;
    merged[col_q] = cellin_q;
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    ram_we     = 1'b0;
    ram_waddr  = r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = lifeg_pkg::IDX_W'(row);
    cnt_ctrl   = '0;
    done_next  = 1'b0;
    cell_next  = 1'b0;
    count_next = '0;
    case (state)
      lifeg_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (r == lifeg_pkg::LAST_ROW) begin
          r_next     = '0;
          state_next = lifeg_pkg::S_IDLE;
        end else begin
          r_next = r + 1'b1;
        end
      end
      lifeg_pkg::S_IDLE: begin
        ram_re = 1'b1;
        if (start) begin
          state_next = lifeg_pkg::S_ACC;
        end
      end
      lifeg_pkg::S_ACC: begin
        case (cmd_q)
          lifeg_pkg::CMD_WRITE: begin
            ram_we     = inside_q;
            ram_waddr  = row_q;
            ram_wdata  = merged;
            done_next  = 1'b1;
            state_next = lifeg_pkg::S_IDLE;
          end
          lifeg_pkg::CMD_READ: begin
            cell_next  = inside_q & ram_rdata[col_q];
            done_next  = 1'b1;
            state_next = lifeg_pkg::S_IDLE;
          end
          lifeg_pkg::CMD_STEP: begin
            ram_re         = 1'b1;
            ram_raddr      = lifeg_pkg::LAST_ROW;
            cnt_ctrl.clear = 1'b1;
            r_next         = '0;
            state_next     = lifeg_pkg::S_P0;
          end
          default: begin
            done_next  = 1'b1;
            state_next = lifeg_pkg::S_IDLE;
          end
        endcase
      end
      lifeg_pkg::S_P0: begin
        ram_re     = 1'b1;
        ram_raddr  = '0;
        state_next = lifeg_pkg::S_P1;
      end
      lifeg_pkg::S_P1: begin
        ram_re     = 1'b1;
        ram_raddr  = lifeg_pkg::IDX_W'(1);
        state_next = lifeg_pkg::S_P2;
      end
      lifeg_pkg::S_P2: begin
        state_next = lifeg_pkg::S_CALC;
      end
      lifeg_pkg::S_CALC: begin
        if (!cnt_busy) begin
          ram_we        = 1'b1;
          ram_waddr     = r;
          ram_wdata     = new_row;
          cnt_ctrl.load = 1'b1;
          ram_re        = (32'(r2) < lifeg_pkg::GRID_SIDE);
          ram_raddr     = r2[lifeg_pkg::IDX_W-1:0];
          state_next    = lifeg_pkg::S_SHIFT;
        end
      end
      lifeg_pkg::S_SHIFT: begin
        if (r == lifeg_pkg::LAST_ROW) begin
          state_next = lifeg_pkg::S_WAIT;
        end else begin
          r_next     = r + 1'b1;
          state_next = lifeg_pkg::S_CALC;
        end
      end
      lifeg_pkg::S_WAIT: begin
        if (!cnt_busy) begin
          done_next  = 1'b1;
          count_next = cnt_total;
          state_next = lifeg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lifeg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lifeg_pkg::S_CLEAR;
      r         <= '0;
      done      <= 1'b0;
      edge_mode <= 1'b0;
    end else begin
      state <= state_next;
      r     <= r_next;
      done  <= done_next;
      if (cfg_we) begin
        edge_mode <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_out      <= cell_next;
    changed_count <= count_next;
    if (state == lifeg_pkg::S_IDLE && start) begin
      cmd_q    <= lifeg_pkg::cmd_t'(command);
      col_q    <= lifeg_pkg::IDX_W'(column);
      row_q    <= lifeg_pkg::IDX_W'(row);
      cellin_q <= cell_in;
      inside_q <= inside_in;
    end
    case (state)
      lifeg_pkg::S_P0: begin
        above <= ram_rdata;
      end
      lifeg_pkg::S_P1: begin
        mid   <= ram_rdata;
        first <= ram_rdata;
      end
      lifeg_pkg::S_P2: begin
        below <= ram_rdata;
      end
      lifeg_pkg::S_SHIFT: begin
        above <= mid;
        mid   <= below;
        below <= (32'(r2) == lifeg_pkg::GRID_SIDE) ? first : ram_rdata;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  a_read_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && cell_out) |-> (changed_count == '0))
    else $error("read result carries a change count");

  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !cnt_busy) else $error("change counter running while idle");
`endif

endmodule
`default_nettype wire

FILE: bench/life_automaton_grid_engine_top_tb.sv
// Self-checking bench for life_automaton_grid_engine_top: write/read/step commands
// against an in-bench B3/S23 grid predictor, under dead-border and wrap edges.
// Depends on lifeg_pkg and the RTL top.
`timescale 1ns / 1ps
module life_automaton_grid_engine_top_tb;
  import lifeg_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    cmd_t                 cmd;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic                 alive;
  } beat_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic                 alive;
    logic [COUNT_W-1:0]   flips;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  cmd_t               command = CMD_NONE;
  logic [COORD_W-1:0] column = '0;
  logic [COORD_W-1:0] row = '0;
  logic               cell_in = 1'b0;
  logic               done;
  logic               cell_out;
  logic [COUNT_W-1:0] changed_count;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  beat_t    command_q[$];
  outcome_t outcome_q[$];
  beat_t    cur_beat;
  int       gap_left = 0;
  bit       no_idle = 1'b0;

  bit       life_grid[GRID_SIDE][GRID_SIDE];
  bit       next_gen[GRID_SIDE][GRID_SIDE];
  bit       wrap_mode = 1'b0;

  int       errors = 0;
  int       beats_in = 0;
  int       generations = 0;
  int       flips_total = 0;
  int       results_checked = 0;
  int       idle_cycles = 0;
  bit       saw_dead = 1'b0;
  bit       saw_wrap = 1'b0;

  life_automaton_grid_engine_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .column       (column),
    .row          (row),
    .cell_in      (cell_in),
    .done         (done),
    .cell_out     (cell_out),
    .changed_count(changed_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int live_neighbours(int x, int y);
    int n, dx, dy, cx, cy;
    n = 0;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        if (dx == 0 && dy == 0) continue;
        cx = x + dx;
        cy = y + dy;
        if (wrap_mode) begin
          cx = (cx + GRID_SIDE) % GRID_SIDE;
          cy = (cy + GRID_SIDE) % GRID_SIDE;
        end else if (cx < 0 || cy < 0 || cx >= GRID_SIDE || cy >= GRID_SIDE) begin
          continue;
        end
        n += life_grid[cy][cx];
      end
    end
    return n;
  endfunction

  function automatic int advance_generation();
    int x, y, n, flips;
    flips = 0;
    for (y = 0; y < GRID_SIDE; y++) begin
      for (x = 0; x < GRID_SIDE; x++) begin
        n = live_neighbours(x, y);
        next_gen[y][x] = (n == 3) || (n == 2 && life_grid[y][x]);
      end
    end
    for (y = 0; y < GRID_SIDE; y++) begin
      for (x = 0; x < GRID_SIDE; x++) begin
        if (next_gen[y][x] != life_grid[y][x]) begin
          if (flips < int'(COUNT_MAX)) flips++;
          life_grid[y][x] = next_gen[y][x];
        end
      end
    end
    return flips;
  endfunction

  function automatic outcome_t apply_command(beat_t b);
    outcome_t o;
    int       flips;
    o.cmd = b.cmd;
    o.alive = 1'b0;
    o.flips = '0;
    case (b.cmd)
      CMD_WRITE: life_grid[b.row][b.col] = b.alive;
      CMD_READ:  o.alive = life_grid[b.row][b.col];
      CMD_STEP: begin
        flips = advance_generation();
        o.flips = COUNT_W'(flips);
        generations++;
        flips_total += flips;
        if (wrap_mode) saw_wrap = 1'b1;
        else saw_dead = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_anchor();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(GRID_SIDE - 5, GRID_SIDE - 1);
      default: return $urandom_range(0, GRID_SIDE - 1);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && busy === 1'b0) begin
        outcome_q.push_back(apply_command(cur_beat));
        beats_in++;
      end
      if (!start || busy === 1'b0) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (command_q.size() != 0) begin
          cur_beat = command_q.pop_front();
          command <= cur_beat.cmd;
          column  <= cur_beat.col;
          row     <= cur_beat.row;
          cell_in <= cur_beat.alive;
          start   <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: cell_out %0b changed_count %0d",
                 $realtime, cell_out, changed_count);
        errors++;
      end else begin
        automatic outcome_t o = outcome_q.pop_front();
        if (cell_out !== o.alive) begin
          $display("%0t: %s cell_out expected %0b actual %0b",
                   $realtime, o.cmd.name(), o.alive, cell_out);
          errors++;
        end
        if (changed_count !== o.flips) begin
          $display("%0t: %s changed_count expected %0d actual %0d",
                   $realtime, o.cmd.name(), o.flips, changed_count);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("life_automaton_grid_engine_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_beat(cmd_t c, int x, int y, bit v);
    beat_t b;
    b.cmd = c;
    b.col = x[COORD_W-1:0];
    b.row = y[COORD_W-1:0];
    b.alive = v;
    command_q.push_back(b);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (command_q.size() != 0 || start || outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_edge_mode(bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    wrap_mode = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // patches of live cells, evolved and probed, mixed with raw noise
  task automatic add_random_phase(int n);
    int added, x0, y0, w;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 2) begin
        add_beat(cmd_t'($urandom_range(0, 3)), $urandom_range(0, GRID_SIDE - 1),
                 $urandom_range(0, GRID_SIDE - 1), $urandom_range(0, 1));
        added++;
      end else begin
        x0 = pick_anchor();
        y0 = pick_anchor();
        w = $urandom_range(3, 6);
        repeat ($urandom_range(3, 10)) begin
          add_beat(CMD_WRITE, x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, w - 1),
                   $urandom_range(0, 3) != 0);
          added++;
        end
        repeat ($urandom_range(1, 2)) begin
          add_beat(CMD_STEP, $urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1),
                   $urandom_range(0, 1));
          added++;
        end
        repeat ($urandom_range(1, 3)) begin
          add_beat(CMD_READ, x0 + $urandom_range(0, w + 1) - 1,
                   y0 + $urandom_range(0, w + 1) - 1, $urandom_range(0, 1));
          added++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (busy !== 1'b0);

    // dead border: reset contents, unused command, blinker on the top edge
    write_edge_mode(1'b0);
    add_beat(CMD_READ, 0, 0, 1);
    add_beat(CMD_NONE, GRID_SIDE - 1, GRID_SIDE - 1, 1);
    add_beat(CMD_WRITE, GRID_SIDE - 1, GRID_SIDE - 1, 1);
    add_beat(CMD_READ, GRID_SIDE - 1, GRID_SIDE - 1, 0);
    add_beat(CMD_WRITE, 10, 0, 1);
    add_beat(CMD_WRITE, 11, 0, 1);
    add_beat(CMD_WRITE, 12, 0, 1);
    add_beat(CMD_STEP, GRID_SIDE - 1, GRID_SIDE - 1, 1);
    add_beat(CMD_READ, 11, 1, 0);
    add_beat(CMD_READ, 11, 0, 0);
    add_beat(CMD_STEP, 0, 0, 0);
    add_beat(CMD_WRITE, GRID_SIDE - 1, GRID_SIDE - 1, 0);
    wait_drained();

    // wrap: blinker across the side seam, corner cells meeting diagonally
    write_edge_mode(1'b1);
    add_beat(CMD_WRITE, GRID_SIDE - 1, 64, 1);
    add_beat(CMD_WRITE, 0, 64, 1);
    add_beat(CMD_WRITE, 1, 64, 1);
    add_beat(CMD_WRITE, 0, 0, 1);
    add_beat(CMD_WRITE, GRID_SIDE - 1, 0, 1);
    add_beat(CMD_WRITE, 0, GRID_SIDE - 1, 1);
    add_beat(CMD_STEP, 0, 0, 0);
    add_beat(CMD_READ, GRID_SIDE - 1, GRID_SIDE - 1, 1);
    add_beat(CMD_READ, 0, 63, 1);
    add_beat(CMD_STEP, GRID_SIDE - 1, GRID_SIDE - 1, 1);
    add_beat(CMD_READ, 0, 65, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      write_edge_mode(phase[0] ? 1'b1 : 1'b0);
      no_idle = ($urandom_range(0, 3) == 0);
      add_random_phase(18);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d commands accepted, %0d generations (%0d cells flipped), %0d results checked",
             beats_in, generations, flips_total, results_checked);
    $display("generations under dead border: %0s, under wrap: %0s",
             saw_dead ? "yes" : "no", saw_wrap ? "yes" : "no");
    if (errors == 0) begin
      $display("life_automaton_grid_engine_top_tb: done, clean");
    end else begin
      $display("life_automaton_grid_engine_top_tb: done, errors");
    end
    $finish;
  end

endmodule
